FILE: rtl/ssnd_pkg.sv
package ssnd_pkg;

  // Microcode field widths
  localparam int STEP_W = 3;

  typedef logic [STEP_W-1:0] step_t;

  // Datapath operations
  typedef enum logic [1:0] {
    OP_NOP       = 2'd0,
    OP_DIGIT     = 2'd1,
    OP_LOAD_FRAC = 2'd2,
    OP_EMIT      = 2'd3
  } uop_t;

  // Jump conditions
  typedef enum logic [1:0] {
    CND_ALWAYS    = 2'd0,
    CND_IN_XFER   = 2'd1,
    CND_CNT_ZERO  = 2'd2,
    CND_UPD_OR_LE = 2'd3   // update flag at the check step, last emit in EMIT
  } cond_t;

  // One control word: operation, condition, target if true, target if false
  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t tgt_t;
    step_t tgt_f;
  } ucode_t;

  // Program step numbers
  localparam step_t ST_WAIT      = 3'd0;
  localparam step_t ST_INT_DIG   = 3'd1;
  localparam step_t ST_LOAD_FRAC = 3'd2;
  localparam step_t ST_FRAC_DIG  = 3'd3;
  localparam step_t ST_CHECK     = 3'd4;
  localparam step_t ST_EMIT      = 3'd5;

  // Control store
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    unique case (step)
      ST_WAIT:      w = '{OP_NOP,       CND_IN_XFER,   ST_INT_DIG,   ST_WAIT};
      ST_INT_DIG:   w = '{OP_DIGIT,     CND_CNT_ZERO,  ST_LOAD_FRAC, ST_INT_DIG};
      ST_LOAD_FRAC: w = '{OP_LOAD_FRAC, CND_ALWAYS,    ST_FRAC_DIG,  ST_FRAC_DIG};
      ST_FRAC_DIG:  w = '{OP_DIGIT,     CND_CNT_ZERO,  ST_CHECK,     ST_FRAC_DIG};
      ST_CHECK:     w = '{OP_NOP,       CND_UPD_OR_LE, ST_EMIT,      ST_WAIT};
      ST_EMIT:      w = '{OP_EMIT,      CND_UPD_OR_LE, ST_WAIT,      ST_EMIT};
      default:      w = '{OP_NOP,       CND_ALWAYS,    ST_WAIT,      ST_WAIT};
    endcase
    return w;
  endfunction

  // Seven-segment patterns, bits 0-6 are a-g
  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0:    p = 8'b0011_1111;
      4'd1:    p = 8'b0000_0110;
      4'd2:    p = 8'b0101_1011;
      4'd3:    p = 8'b0100_1111;
      4'd4:    p = 8'b0110_0110;
      4'd5:    p = 8'b0110_1101;
      4'd6:    p = 8'b0111_1101;
      4'd7:    p = 8'b0000_0111;
      4'd8:    p = 8'b0111_1111;
      4'd9:    p = 8'b0110_1111;
      default: p = 8'b0000_0000;
    endcase
    return p;
  endfunction

  localparam logic [7:0] SEG_POINT = 8'h80;

  // Reciprocal of ten for 16-bit operands: q = (v * RECIP10) >> RECIP_SH
  localparam logic [15:0] RECIP10  = 16'd52429;
  localparam int          RECIP_SH = 19;

endpackage

FILE: rtl/seven_segment_number_display.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   int/frac value, pos, len; flags
// out      output     out_valid / out_stall digit_index, segments, last
// cfg      input      cfg_wr_en             cfg_flash_mask
//
// An item passes through the wait step, one divide-by-ten step per digit plus a
// closing step for each part, the fraction load and the update check. Update
// adds DIGITS emit steps, each held for as long as the output is stalled.
// Synchronous active-low reset clears the digit buffer, flash mask and
// sequencer. in_stall is high whenever the sequencer is away from its wait step.
module seven_segment_number_display #(
  parameter int DIGITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_int_value,
  input  logic [1:0]  in_int_pos,
  input  logic [2:0]  in_int_len,
  input  logic [15:0] in_frac_value,
  input  logic [1:0]  in_frac_start,
  input  logic [2:0]  in_frac_count,
  input  logic        in_mark_point,
  input  logic        in_update,
  input  logic        in_blink_on,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_digit_index,
  output logic [7:0]  out_segments,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_flash_mask
);
  import ssnd_pkg::*;

  localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // Sequencer and datapath registers
  step_t       step_r, step_nxt;
  logic [3:0]  flash_r;
  logic [7:0]  buf_r [DIGITS];
  logic [15:0] val_r, val_nxt;
  logic [3:0]  at_r, at_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pt_r, pt_nxt;
  logic [15:0] fval_r;
  logic [1:0]  fpos_r;
  logic [2:0]  flen_r;
  logic        upd_r, blink_r;
  logic [IDX_W-1:0] d_r, d_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  oidx_r, oidx_nxt;
  logic [7:0]  oseg_r, oseg_nxt;
  logic        olast_r, olast_nxt;

  ucode_t      uw;
  logic        in_xfer, slot_free, d_last, cond_ok;
  logic [31:0] prod;
  logic [15:0] quot;
  logic [3:0]  rem;
  logic [7:0]  pat;
  logic        wr_en;
  logic [2:0]  d_ext;
  logic        flashing;

  assign uw       = ucode_rom(step_r);
  assign in_stall = (step_r != ST_WAIT);
  assign in_xfer  = in_valid && !in_stall;
  assign slot_free = !ov_r || !out_stall;
  assign d_last   = (d_r == IDX_W'(DIGITS - 1));

  // Divide by ten with remainder
  assign prod = 32'(val_r) * 32'(RECIP10);
  assign quot = 16'(prod >> RECIP_SH);
  assign rem  = 4'(val_r - ((quot << 3) + (quot << 1)));
  assign pat  = seg_pattern(rem) | (pt_r ? SEG_POINT : 8'h00);
  assign wr_en = (uw.op == OP_DIGIT) && (cnt_r != 3'd0) &&
                 ({1'b0, at_r} < 5'(DIGITS));

  // Flash mask covers the first four digits only
  assign d_ext    = 3'(d_r);
  assign flashing = !d_ext[2] && flash_r[d_ext[1:0]];

  // Jump condition
  always_comb begin
    unique case (uw.cond)
      CND_ALWAYS:    cond_ok = 1'b1;
      CND_IN_XFER:   cond_ok = in_xfer;
      CND_CNT_ZERO:  cond_ok = (cnt_r == 3'd0);
      CND_UPD_OR_LE: cond_ok = (uw.op == OP_EMIT) ? (slot_free && d_last) : upd_r;
      default:       cond_ok = 1'b0;
    endcase
    step_nxt = cond_ok ? uw.tgt_t : uw.tgt_f;
  end

  // Datapath next state
  always_comb begin
    val_nxt   = val_r;
    at_nxt    = at_r;
    cnt_nxt   = cnt_r;
    pt_nxt    = pt_r;
    d_nxt     = d_r;
    ov_nxt    = ov_r && out_stall;
    oidx_nxt  = oidx_r;
    oseg_nxt  = oseg_r;
    olast_nxt = olast_r;
    unique case (uw.op)
      OP_NOP: begin
        if (in_xfer) begin
          val_nxt = in_int_value;
          at_nxt  = 4'(in_int_pos);
          cnt_nxt = in_int_len;
          pt_nxt  = in_mark_point;
        end
        d_nxt = '0;
      end
      OP_DIGIT: begin
        if (cnt_r != 3'd0) begin
          val_nxt = quot;
          at_nxt  = at_r + 4'd1;
          cnt_nxt = cnt_r - 3'd1;
          pt_nxt  = 1'b0;
        end
      end
      OP_LOAD_FRAC: begin
        val_nxt = fval_r;
        at_nxt  = 4'(fpos_r);
        cnt_nxt = flen_r;
        pt_nxt  = 1'b0;
      end
      OP_EMIT: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          oidx_nxt  = 2'(d_r);
          oseg_nxt  = (flashing && !blink_r) ? 8'h00 : buf_r[d_r];
          olast_nxt = d_last;
          d_nxt     = d_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_WAIT;
      ov_r    <= 1'b0;
      flash_r <= 4'd0;
      for (int i = 0; i < DIGITS; i++) begin
        buf_r[i] <= 8'h00;
      end
    end else begin
      step_r <= step_nxt;
      ov_r   <= ov_nxt;
      if (cfg_wr_en) begin
        flash_r <= cfg_flash_mask;
      end
      if (wr_en) begin
        buf_r[at_r[IDX_W-1:0]] <= pat;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    at_r    <= at_nxt;
    cnt_r   <= cnt_nxt;
    pt_r    <= pt_nxt;
    d_r     <= d_nxt;
    oidx_r  <= oidx_nxt;
    oseg_r  <= oseg_nxt;
    olast_r <= olast_nxt;
    if (in_xfer) begin
      fval_r  <= in_frac_value;
      fpos_r  <= in_frac_start;
      flen_r  <= in_frac_count;
      upd_r   <= in_update;
      blink_r <= in_blink_on;
    end
  end

  assign out_valid       = ov_r;
  assign out_digit_index = oidx_r;
  assign out_segments    = oseg_r;
  assign out_last        = olast_r;

endmodule

FILE: tb/testbench.sv
module testbench;
  import ssnd_pkg::*;

  localparam int DIGIT_COUNT = 4;
  localparam int CYCLE_LIMIT = 200000;
  // cycles to let an item with no update finish before touching the mask
  localparam int SETTLE_CYCLES = 20;

  // segment patterns for 0..9, bits 0-6 are a-g
  localparam logic [7:0] SEG_OF_DIGIT [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  typedef struct {
    logic [15:0] int_value;
    logic [1:0]  int_pos;
    logic [2:0]  int_len;
    logic [15:0] frac_value;
    logic [1:0]  frac_start;
    logic [2:0]  frac_count;
    logic        mark_point;
    logic        update;
    logic        blink_on;
  } disp_item_t;

  typedef struct {
    logic [1:0] digit_index;
    logic [7:0] segments;
    logic       last;
  } shown_digit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_int_value = '0;
  logic [1:0]  in_int_pos = '0;
  logic [2:0]  in_int_len = '0;
  logic [15:0] in_frac_value = '0;
  logic [1:0]  in_frac_start = '0;
  logic [2:0]  in_frac_count = '0;
  logic        in_mark_point = 1'b0;
  logic        in_update = 1'b0;
  logic        in_blink_on = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_digit_index;
  logic [7:0]  out_segments;
  logic        out_last;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_flash_mask = '0;

  // shadow of the display state
  logic [7:0]   shadow_digits [DIGIT_COUNT];
  logic [3:0]   blink_mask;
  shown_digit_t pending_digits [$];
  int           error_count = 0;
  int           cycle_count = 0;

  seven_segment_number_display i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_int_value    (in_int_value),
    .in_int_pos      (in_int_pos),
    .in_int_len      (in_int_len),
    .in_frac_value   (in_frac_value),
    .in_frac_start   (in_frac_start),
    .in_frac_count   (in_frac_count),
    .in_mark_point   (in_mark_point),
    .in_update       (in_update),
    .in_blink_on     (in_blink_on),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digit_index (out_digit_index),
    .out_segments    (out_segments),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_flash_mask  (cfg_flash_mask)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // receiver stall pattern: free-running, busy random, and long regular runs
  int stall_mode = 0;
  int stall_tick = 0;
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 48 == 0)
      stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ((stall_tick % 9) < 5);
    endcase
  end

  // check each digit transfer against the oldest prediction
  always @(posedge clk) begin
    shown_digit_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected digit idx=%0d seg=%h last=%b", $time,
                 out_digit_index, out_segments, out_last);
        error_count++;
      end else begin
        want = pending_digits.pop_front();
        if (out_digit_index !== want.digit_index || out_segments !== want.segments ||
            out_last !== want.last) begin
          $display("%0t: digit mismatch: expected idx=%0d seg=%h last=%b, %s",
                   $time, want.digit_index, want.segments, want.last,
                   $sformatf("actual idx=%0d seg=%h last=%b",
                             out_digit_index, out_segments, out_last));
          error_count++;
        end
      end
    end
  end

  // write one part, lowest digit first; positions past the buffer are dropped
  function automatic void place_part(input logic [15:0] value, input logic [1:0] pos,
                                     input logic [2:0] len, input logic with_point);
    logic [15:0] rest;
    logic [7:0]  pat;
    int          at;
    rest = value;
    for (int k = 0; k < len; k++) begin
      at = pos + k;
      pat = SEG_OF_DIGIT[rest % 10];
      if (with_point && k == 0)
        pat = pat | SEG_POINT;
      if (at < DIGIT_COUNT)
        shadow_digits[at] = pat;
      rest = rest / 10;
    end
  endfunction

  // integer first, then fraction; a refresh queues every digit
  function automatic void predict_display(input disp_item_t it);
    shown_digit_t d;
    place_part(it.int_value, it.int_pos, it.int_len, it.mark_point);
    place_part(it.frac_value, it.frac_start, it.frac_count, 1'b0);
    if (it.update) begin
      for (int k = 0; k < DIGIT_COUNT; k++) begin
        d.digit_index = k[1:0];
        d.segments = shadow_digits[k];
        if (k < 4 && blink_mask[k] && !it.blink_on)
          d.segments = '0;
        d.last = (k == DIGIT_COUNT - 1);
        pending_digits.push_back(d);
      end
    end
  endfunction

  function automatic disp_item_t make_item(input logic [15:0] iv, input int ip, input int il,
                                           input logic [15:0] fv, input int fp, input int fl,
                                           input bit mp, input bit up, input bit bl);
    disp_item_t it;
    it.int_value = iv;
    it.int_pos = 2'(ip);
    it.int_len = 3'(il);
    it.frac_value = fv;
    it.frac_start = 2'(fp);
    it.frac_count = 3'(fl);
    it.mark_point = mp;
    it.update = up;
    it.blink_on = bl;
    return it;
  endfunction

  function automatic logic [15:0] random_value();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 9));
      1: return 16'($urandom_range(0, 9999));
      2: return 16'hFFFF - 16'($urandom_range(0, 600));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic disp_item_t random_item();
    return make_item(random_value(), $urandom_range(0, 3), $urandom_range(0, 4),
                     random_value(), $urandom_range(0, 3), $urandom_range(0, 4),
                     1'($urandom_range(0, 1)), ($urandom_range(0, 9) < 7),
                     1'($urandom_range(0, 1)));
  endfunction

  // drive one item at the falling edge and hold it until transferred
  task automatic send_item(input disp_item_t it);
    @(negedge clk);
    in_valid = 1'b1;
    in_int_value = it.int_value;
    in_int_pos = it.int_pos;
    in_int_len = it.int_len;
    in_frac_value = it.frac_value;
    in_frac_start = it.frac_start;
    in_frac_count = it.frac_count;
    in_mark_point = it.mark_point;
    in_update = it.update;
    in_blink_on = it.blink_on;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    predict_display(it);
  endtask

  task automatic sender_gap(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // hold off until every queued digit has arrived and the block has settled
  task automatic wait_idle();
    sender_gap(1);
    while (pending_digits.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_blink_mask(input logic [3:0] mask);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_flash_mask = mask;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    blink_mask = mask;
  endtask

  // buffer after reset, then extremes, overlap, overflow and padding
  task automatic test_digit_writes();
    send_item(make_item(16'd0, 0, 0, 16'd0, 0, 0, 1'b0, 1'b1, 1'b1));
    send_item(make_item(16'hFFFF, 0, 4, 16'd0, 0, 0, 1'b1, 1'b1, 1'b1));
    send_item(make_item(16'd1234, 0, 4, 16'd56, 2, 2, 1'b0, 1'b1, 1'b0));
    send_item(make_item(16'd5678, 0, 4, 16'd90, 0, 2, 1'b1, 1'b1, 1'b1));
    // digits beyond the buffer are dropped but place values hold
    send_item(make_item(16'd4321, 3, 4, 16'd0, 0, 0, 1'b1, 1'b1, 1'b1));
    send_item(make_item(16'd0, 0, 0, 16'hFFFF, 3, 4, 1'b0, 1'b1, 1'b1));
    // length above the value's digit count pads with zero patterns
    send_item(make_item(16'd7, 1, 3, 16'd9, 0, 1, 1'b0, 1'b0, 1'b1));
    send_item(make_item(16'd0, 0, 0, 16'd0, 0, 0, 1'b0, 1'b1, 1'b1));
    // point requested with no integer digits sets nothing
    send_item(make_item(16'd8, 0, 0, 16'd23, 0, 2, 1'b1, 1'b1, 1'b1));
    send_item(make_item(16'd0, 2, 1, 16'd3, 2, 1, 1'b1, 1'b1, 1'b1));
    send_item(make_item(16'd65535, 2, 4, 16'd1, 1, 4, 1'b1, 1'b1, 1'b0));
  endtask

  // flashing digits blank only in the off phase
  task automatic test_blink_mask();
    write_blink_mask(4'hF);
    send_item(make_item(16'd9876, 0, 4, 16'd0, 0, 0, 1'b1, 1'b1, 1'b0));
    send_item(make_item(16'd0, 0, 0, 16'd0, 0, 0, 1'b0, 1'b1, 1'b1));
    write_blink_mask(4'h5);
    send_item(make_item(16'd2468, 0, 4, 16'd0, 0, 0, 1'b0, 1'b1, 1'b0));
    send_item(make_item(16'd0, 0, 0, 16'd0, 0, 0, 1'b0, 1'b1, 1'b1));
    write_blink_mask(4'hA);
    send_item(make_item(16'd13, 0, 2, 16'd57, 2, 2, 1'b1, 1'b1, 1'b0));
    write_blink_mask(4'h0);
    send_item(make_item(16'd0, 0, 0, 16'd0, 0, 0, 1'b0, 1'b1, 1'b0));
  endtask

  // random traffic in bursts, with mask changes and a full drain midway
  task automatic test_random_traffic();
    int burst_left;
    burst_left = 0;
    for (int n = 0; n < 130; n++) begin
      if (n % 40 == 39)
        write_blink_mask(4'($urandom_range(0, 15)));
      else if (n == 65)
        wait_idle();
      else if (burst_left == 0) begin
        sender_gap($urandom_range(1, 8));
        burst_left = $urandom_range(1, 12);
      end
      send_item(random_item());
      if (burst_left > 0)
        burst_left--;
    end
  endtask

  initial begin
    blink_mask = '0;
    for (int k = 0; k < DIGIT_COUNT; k++)
      shadow_digits[k] = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_digit_writes();
    test_blink_mask();
    test_random_traffic();

    // drain, then allow for any trailing transfer
    sender_gap(1);
    while (pending_digits.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
